[rtl/core/ccvr_pkg.sv]
`timescale 1ns / 1ps

package ccvr_pkg;

  // Default number of fraction bits of positions, velocities and weights.
  localparam int unsigned FracBitsDef = 16;
  // Fraction bits of the bounce factors.
  localparam int unsigned BounceBits = 16;
  // Bit position that the larger offset component is normalised to.
  localparam int unsigned NormMsb = 14;
  // Result bits of the square root, one per stage.
  localparam int unsigned SqrtSteps = 16;

  // Velocities and the values derived early from them, the offsets and the bounce factors, carried down the pipe.
  typedef struct packed {
    logic signed [31:0] vax;
    logic signed [31:0] vay;
    logic signed [31:0] vbx;
    logic signed [31:0] vby;
    logic signed [32:0] rvx;
    logic signed [32:0] rvy;
    logic [17:0]        r;
    logic               neg_x;
    logic               neg_y;
    logic               coinc;
  } vel_t;

  // Operands of the two mass weight divisions.
  typedef struct packed {
    logic [32:0] sum;
    logic [33:0] rem_a;
    logic [33:0] rem_b;
  } wdiv_t;

  // Saturate a wide signed value to the signed 32-bit range.
  function automatic logic [31:0] sat32(input logic signed [40:0] v);
    logic [31:0] res;
    if (v > 41'sd2147483647) begin
      res = 32'h7FFF_FFFF;
    end else if (v < -41'sd2147483648) begin
      res = 32'h8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

[rtl/core/circle_collision_velocity_response.sv]
`timescale 1ns / 1ps
// An accepted request passes through stages 1 to 3, the square root and divider pipelines and P1 to P6 to done_o.
// Throughput: one request per cycle; the 16-stage square root and the divider that yields
// one quotient bit per stage are fully pipelined, so busy is only high around reset.
// Reset: asynchronous, active low; it clears every valid bit and holds busy high until the
// first clock edge after release. The receiver cannot stall; done_o is high for one cycle per result.
module circle_collision_velocity_response #(
  parameter int unsigned FRAC_BITS = ccvr_pkg::FracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] pos_a_x_i,
  input  logic signed [31:0] pos_a_y_i,
  input  logic signed [31:0] pos_b_x_i,
  input  logic signed [31:0] pos_b_y_i,
  input  logic signed [31:0] vel_a_x_i,
  input  logic signed [31:0] vel_a_y_i,
  input  logic signed [31:0] vel_b_x_i,
  input  logic signed [31:0] vel_b_y_i,
  input  logic [31:0]        mass_a_i,
  input  logic [31:0]        mass_b_i,
  input  logic [16:0]        bounce_a_i,
  input  logic [16:0]        bounce_b_i,
  output logic signed [31:0] new_vel_a_x_o,
  output logic signed [31:0] new_vel_a_y_o,
  output logic signed [31:0] new_vel_b_x_o,
  output logic signed [31:0] new_vel_b_y_o,
  output logic               impulse_applied_o,
  output logic               done_o
);
  import ccvr_pkg::*;

  localparam int unsigned QW    = FRAC_BITS + 1;   // quotient bits, value at most 2^FRAC_BITS
  localparam int unsigned NW    = FRAC_BITS + 2;   // signed normal component
  localparam int unsigned RelW  = 36;
  localparam int unsigned TW    = 36;
  localparam int unsigned JW    = 38;
  localparam int unsigned DW    = 40;
  localparam logic [5:0]  NormPos = 6'(NormMsb);
  localparam logic [15:0] LenMin  = 16'(1 << NormMsb);
  localparam logic [QW-1:0] HalfW = QW'(1) << (FRAC_BITS - 1);
  localparam logic [QW-1:0] OneW  = QW'(1) << FRAC_BITS;

  logic busy_q;
  logic accept;

  assign busy   = busy_q;
  assign accept = start && !busy_q;

  // Busy only until the first edge after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: offsets, relative velocity, bounce product and weight operands.
  logic               s1_vld_q;
  logic signed [32:0] s1_dx_q, s1_dy_q;
  vel_t               s1_vel_q;
  wdiv_t              s1_w_q;
  logic [33:0]        bounce_prod;

  assign bounce_prod = 34'(bounce_a_i) * 34'(bounce_b_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_dx_q        <= 33'(pos_a_x_i) - 33'(pos_b_x_i);
    s1_dy_q        <= 33'(pos_a_y_i) - 33'(pos_b_y_i);
    s1_vel_q.vax   <= vel_a_x_i;
    s1_vel_q.vay   <= vel_a_y_i;
    s1_vel_q.vbx   <= vel_b_x_i;
    s1_vel_q.vby   <= vel_b_y_i;
    s1_vel_q.rvx   <= 33'(vel_a_x_i) - 33'(vel_b_x_i);
    s1_vel_q.rvy   <= 33'(vel_a_y_i) - 33'(vel_b_y_i);
    s1_vel_q.r     <= bounce_prod[33:BounceBits];
    s1_vel_q.neg_x <= 1'b0;
    s1_vel_q.neg_y <= 1'b0;
    s1_vel_q.coinc <= 1'b0;
    s1_w_q.sum     <= {1'b0, mass_a_i} + {1'b0, mass_b_i};
    s1_w_q.rem_a   <= {2'b00, mass_a_i};
    s1_w_q.rem_b   <= {2'b00, mass_b_i};
  end

  // ---------------------------------------------------------------------------
  // Stage 2: magnitudes, signs and the larger magnitude.
  logic        s2_vld_q;
  logic [32:0] s2_ax_q, s2_ay_q, s2_mx_q;
  vel_t        s2_vel_q;
  wdiv_t       s2_w_q;
  logic [32:0] abs_x, abs_y;
  vel_t        vel2;

  assign abs_x = s1_dx_q[32] ? 33'(-s1_dx_q) : 33'(s1_dx_q);
  assign abs_y = s1_dy_q[32] ? 33'(-s1_dy_q) : 33'(s1_dy_q);

  // Add the offset signs and the coincidence flag to the carried velocities.
  always_comb begin
    vel2       = s1_vel_q;
    vel2.neg_x = s1_dx_q[32];
    vel2.neg_y = s1_dy_q[32];
    vel2.coinc = (s1_dx_q == '0) && (s1_dy_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_ax_q  <= abs_x;
    s2_ay_q  <= abs_y;
    s2_mx_q  <= (abs_x > abs_y) ? abs_x : abs_y;
    s2_vel_q <= vel2;
    s2_w_q   <= s1_w_q;
  end

  // ---------------------------------------------------------------------------
  // Stage 3: normalise so that the larger magnitude has its top bit at NormMsb.
  logic        s3_vld_q;
  logic [14:0] s3_ax_q, s3_ay_q;
  vel_t        s3_vel_q;
  wdiv_t       s3_w_q;
  logic [5:0]  msb;
  logic [14:0] ax_norm, ay_norm;

  always_comb begin
    msb = '0;
    for (int i = 0; i < 33; i++) begin
      if (s2_mx_q[i]) begin
        msb = 6'(i);
      end
    end
    if (msb >= NormPos) begin
      ax_norm = 15'(s2_ax_q >> (msb - NormPos));
      ay_norm = 15'(s2_ay_q >> (msb - NormPos));
    end else begin
      ax_norm = 15'(s2_ax_q << (NormPos - msb));
      ay_norm = 15'(s2_ay_q << (NormPos - msb));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_ax_q  <= ax_norm;
    s3_ay_q  <= ay_norm;
    s3_vel_q <= s2_vel_q;
    s3_w_q   <= s2_w_q;
  end

  // ---------------------------------------------------------------------------
  // Square root pipeline. Entry 0 holds the sum of squares; each later entry
  // settles one more root bit.
  logic        sq_vld_q  [0:SqrtSteps];
  logic [19:0] sq_rem_q  [0:SqrtSteps];
  logic [15:0] sq_root_q [0:SqrtSteps];
  logic [31:0] sq_src_q  [0:SqrtSteps];
  logic [14:0] sq_ax_q   [0:SqrtSteps];
  logic [14:0] sq_ay_q   [0:SqrtSteps];
  vel_t        sq_vel_q  [0:SqrtSteps];
  wdiv_t       sq_w_q    [0:SqrtSteps];
  logic [29:0] sqr_x, sqr_y;

  assign sqr_x = 30'(s3_ax_q) * 30'(s3_ax_q);
  assign sqr_y = 30'(s3_ay_q) * 30'(s3_ay_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q[0] <= 1'b0;
    end else begin
      sq_vld_q[0] <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_rem_q[0]  <= '0;
    sq_root_q[0] <= '0;
    sq_src_q[0]  <= {1'b0, {1'b0, sqr_x} + {1'b0, sqr_y}};
    sq_ax_q[0]   <= s3_ax_q;
    sq_ay_q[0]   <= s3_ay_q;
    sq_vel_q[0]  <= s3_vel_q;
    sq_w_q[0]    <= s3_w_q;
  end

  for (genvar k = 1; k <= SqrtSteps; k++) begin : g_sqrt
    logic [19:0] rem_sh, trial, rem_d;
    logic [15:0] root_d;

    // Bring down the next two bits and try the next root bit.
    always_comb begin
      rem_sh = {sq_rem_q[k-1][17:0], sq_src_q[k-1][31:30]};
      trial  = {2'b00, sq_root_q[k-1], 2'b01};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {sq_root_q[k-1][14:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {sq_root_q[k-1][14:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[k] <= 1'b0;
      end else begin
        sq_vld_q[k] <= sq_vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      sq_rem_q[k]  <= rem_d;
      sq_root_q[k] <= root_d;
      sq_src_q[k]  <= {sq_src_q[k-1][29:0], 2'b00};
      sq_ax_q[k]   <= sq_ax_q[k-1];
      sq_ay_q[k]   <= sq_ay_q[k-1];
      sq_vel_q[k]  <= sq_vel_q[k-1];
      sq_w_q[k]    <= sq_w_q[k-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Divider pipeline: the normal components over the length and the two mass
  // weights over the mass sum, one quotient bit per stage.
  logic          dv_vld_q [0:QW];
  logic [16:0]   dv_rx_q  [0:QW];
  logic [16:0]   dv_ry_q  [0:QW];
  logic [15:0]   dv_d_q   [0:QW];
  logic [QW-1:0] dv_qx_q  [0:QW];
  logic [QW-1:0] dv_qy_q  [0:QW];
  logic [QW-1:0] dv_qa_q  [0:QW];
  logic [QW-1:0] dv_qb_q  [0:QW];
  vel_t          dv_vel_q [0:QW];
  wdiv_t         dv_w_q   [0:QW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q[0] <= 1'b0;
    end else begin
      dv_vld_q[0] <= sq_vld_q[SqrtSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    dv_rx_q[0]  <= {2'b00, sq_ax_q[SqrtSteps]};
    dv_ry_q[0]  <= {2'b00, sq_ay_q[SqrtSteps]};
    dv_d_q[0]   <= sq_root_q[SqrtSteps];
    dv_qx_q[0]  <= '0;
    dv_qy_q[0]  <= '0;
    dv_qa_q[0]  <= '0;
    dv_qb_q[0]  <= '0;
    dv_vel_q[0] <= sq_vel_q[SqrtSteps];
    dv_w_q[0]   <= sq_w_q[SqrtSteps];
  end

  for (genvar k = 1; k <= QW; k++) begin : g_div
    logic        ge_x, ge_y, ge_a, ge_b;
    logic [16:0] sub_x, sub_y, rx_d, ry_d;
    logic [33:0] sub_a, sub_b;
    wdiv_t       w_d;

    // Restoring step: subtract where the divisor fits, then double the remainder.
    always_comb begin
      ge_x  = dv_rx_q[k-1] >= {1'b0, dv_d_q[k-1]};
      ge_y  = dv_ry_q[k-1] >= {1'b0, dv_d_q[k-1]};
      sub_x = ge_x ? dv_rx_q[k-1] - {1'b0, dv_d_q[k-1]} : dv_rx_q[k-1];
      sub_y = ge_y ? dv_ry_q[k-1] - {1'b0, dv_d_q[k-1]} : dv_ry_q[k-1];
      rx_d  = {sub_x[15:0], 1'b0};
      ry_d  = {sub_y[15:0], 1'b0};
      ge_a  = dv_w_q[k-1].rem_a >= {1'b0, dv_w_q[k-1].sum};
      ge_b  = dv_w_q[k-1].rem_b >= {1'b0, dv_w_q[k-1].sum};
      sub_a = ge_a ? dv_w_q[k-1].rem_a - {1'b0, dv_w_q[k-1].sum} : dv_w_q[k-1].rem_a;
      sub_b = ge_b ? dv_w_q[k-1].rem_b - {1'b0, dv_w_q[k-1].sum} : dv_w_q[k-1].rem_b;
      w_d       = dv_w_q[k-1];
      w_d.rem_a = {sub_a[32:0], 1'b0};
      w_d.rem_b = {sub_b[32:0], 1'b0};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[k] <= 1'b0;
      end else begin
        dv_vld_q[k] <= dv_vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      dv_rx_q[k]  <= rx_d;
      dv_ry_q[k]  <= ry_d;
      dv_d_q[k]   <= dv_d_q[k-1];
      dv_qx_q[k]  <= {dv_qx_q[k-1][QW-2:0], ge_x};
      dv_qy_q[k]  <= {dv_qy_q[k-1][QW-2:0], ge_y};
      dv_qa_q[k]  <= {dv_qa_q[k-1][QW-2:0], ge_a};
      dv_qb_q[k]  <= {dv_qb_q[k-1][QW-2:0], ge_b};
      dv_vel_q[k] <= dv_vel_q[k-1];
      dv_w_q[k]   <= w_d;
    end
  end

  // ---------------------------------------------------------------------------
  // P1: signed normal, weights with the zero-mass case, normal products.
  logic                  p1_vld_q;
  logic signed [NW-1:0]  p1_nx_q, p1_ny_q;
  logic [QW-1:0]         p1_wa_q, p1_wb_q;
  logic signed [NW+32:0] p1_px_q, p1_py_q;
  vel_t                  p1_vel_q;
  logic signed [NW-1:0]  nx, ny;
  logic                  zero_sum;

  assign nx = dv_vel_q[QW].neg_x ? -$signed({1'b0, dv_qx_q[QW]}) : $signed({1'b0, dv_qx_q[QW]});
  assign ny = dv_vel_q[QW].neg_y ? -$signed({1'b0, dv_qy_q[QW]}) : $signed({1'b0, dv_qy_q[QW]});
  assign zero_sum = dv_w_q[QW].sum == '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
    end else begin
      p1_vld_q <= dv_vld_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    p1_nx_q  <= nx;
    p1_ny_q  <= ny;
    p1_wa_q  <= zero_sum ? HalfW : dv_qa_q[QW];
    p1_wb_q  <= zero_sum ? HalfW : dv_qb_q[QW];
    p1_px_q  <= (NW+33)'($signed(dv_vel_q[QW].rvx)) * (NW+33)'(nx);
    p1_py_q  <= (NW+33)'($signed(dv_vel_q[QW].rvy)) * (NW+33)'(ny);
    p1_vel_q <= dv_vel_q[QW];
  end

  // ---------------------------------------------------------------------------
  // P2: relative normal speed and the separating test.
  logic                  p2_vld_q, p2_sep_q;
  logic signed [RelW-1:0] p2_rel_q;
  logic signed [NW-1:0]  p2_nx_q, p2_ny_q;
  logic [QW-1:0]         p2_wa_q, p2_wb_q;
  vel_t                  p2_vel_q;
  logic signed [NW+33:0] dot;
  logic signed [RelW-1:0] rel;

  assign dot = (NW+34)'(p1_px_q) + (NW+34)'(p1_py_q);
  assign rel = RelW'(dot >>> FRAC_BITS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_vld_q <= 1'b0;
    end else begin
      p2_vld_q <= p1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p2_rel_q <= rel;
    p2_sep_q <= !rel[RelW-1] && (rel != '0);
    p2_nx_q  <= p1_nx_q;
    p2_ny_q  <= p1_ny_q;
    p2_wa_q  <= p1_wa_q;
    p2_wb_q  <= p1_wb_q;
    p2_vel_q <= p1_vel_q;
  end

  // ---------------------------------------------------------------------------
  // P3: twice the speed times each weight (A takes B's weight).
  logic                     p3_vld_q, p3_sep_q;
  logic signed [RelW+QW+1:0] p3_pa_q, p3_pb_q;
  logic signed [NW-1:0]     p3_nx_q, p3_ny_q;
  vel_t                     p3_vel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p3_vld_q <= 1'b0;
    end else begin
      p3_vld_q <= p2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p3_pa_q  <= (RelW+QW+2)'($signed({p2_rel_q, 1'b0}))
              * (RelW+QW+2)'($signed({1'b0, p2_wb_q}));
    p3_pb_q  <= (RelW+QW+2)'($signed({p2_rel_q, 1'b0}))
              * (RelW+QW+2)'($signed({1'b0, p2_wa_q}));
    p3_sep_q <= p2_sep_q;
    p3_nx_q  <= p2_nx_q;
    p3_ny_q  <= p2_ny_q;
    p3_vel_q <= p2_vel_q;
  end

  // ---------------------------------------------------------------------------
  // P4: scale by the combined bounce factor.
  logic                 p4_vld_q, p4_sep_q;
  logic signed [TW+18:0] p4_ta_q, p4_tb_q;
  logic signed [NW-1:0] p4_nx_q, p4_ny_q;
  vel_t                 p4_vel_q;
  logic signed [TW-1:0] ta, tb;

  assign ta = TW'(p3_pa_q >>> FRAC_BITS);
  assign tb = TW'(p3_pb_q >>> FRAC_BITS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p4_vld_q <= 1'b0;
    end else begin
      p4_vld_q <= p3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p4_ta_q  <= (TW+19)'(ta) * (TW+19)'($signed({1'b0, p3_vel_q.r}));
    p4_tb_q  <= (TW+19)'(tb) * (TW+19)'($signed({1'b0, p3_vel_q.r}));
    p4_sep_q <= p3_sep_q;
    p4_nx_q  <= p3_nx_q;
    p4_ny_q  <= p3_ny_q;
    p4_vel_q <= p3_vel_q;
  end

  // ---------------------------------------------------------------------------
  // P5: impulse along each normal component.
  logic                    p5_vld_q, p5_sep_q;
  logic signed [JW+NW-1:0] p5_dax_q, p5_day_q, p5_dbx_q, p5_dby_q;
  vel_t                    p5_vel_q;
  logic signed [JW-1:0]    ja, jb;

  assign ja = JW'(p4_ta_q >>> BounceBits);
  assign jb = JW'(p4_tb_q >>> BounceBits);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p5_vld_q <= 1'b0;
    end else begin
      p5_vld_q <= p4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p5_dax_q <= (JW+NW)'(ja) * (JW+NW)'(p4_nx_q);
    p5_day_q <= (JW+NW)'(ja) * (JW+NW)'(p4_ny_q);
    p5_dbx_q <= (JW+NW)'(jb) * (JW+NW)'(p4_nx_q);
    p5_dby_q <= (JW+NW)'(jb) * (JW+NW)'(p4_ny_q);
    p5_sep_q <= p4_sep_q;
    p5_vel_q <= p4_vel_q;
  end

  // ---------------------------------------------------------------------------
  // P6: apply the impulse, saturate, or pass the velocities through.
  logic        done_q, imp_q;
  logic [31:0] out_ax_q, out_ay_q, out_bx_q, out_by_q;
  logic signed [DW-1:0] dax, day, dbx, dby;
  logic signed [40:0]   sum_ax, sum_ay, sum_bx, sum_by;
  logic                 resolve;

  assign dax     = DW'(p5_dax_q >>> FRAC_BITS);
  assign day     = DW'(p5_day_q >>> FRAC_BITS);
  assign dbx     = DW'(p5_dbx_q >>> FRAC_BITS);
  assign dby     = DW'(p5_dby_q >>> FRAC_BITS);
  assign sum_ax  = 41'(p5_vel_q.vax) - 41'(dax);
  assign sum_ay  = 41'(p5_vel_q.vay) - 41'(day);
  assign sum_bx  = 41'(p5_vel_q.vbx) + 41'(dbx);
  assign sum_by  = 41'(p5_vel_q.vby) + 41'(dby);
  assign resolve = !p5_vel_q.coinc && !p5_sep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= p5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    imp_q    <= resolve;
    out_ax_q <= resolve ? sat32(sum_ax) : p5_vel_q.vax;
    out_ay_q <= resolve ? sat32(sum_ay) : p5_vel_q.vay;
    out_bx_q <= resolve ? sat32(sum_bx) : p5_vel_q.vbx;
    out_by_q <= resolve ? sat32(sum_by) : p5_vel_q.vby;
  end

  assign done_o            = done_q;
  assign impulse_applied_o = imp_q;
  assign new_vel_a_x_o     = out_ax_q;
  assign new_vel_a_y_o     = out_ay_q;
  assign new_vel_b_x_o     = out_bx_q;
  assign new_vel_b_y_o     = out_by_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  a_busy_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> !busy)
    else $error("busy raised outside reset");

  a_len_normalised: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_vld_q[0] && !dv_vel_q[0].coinc |-> dv_d_q[0] >= LenMin)
    else $error("square root of a normalised offset below range");

  a_normal_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_vld_q[QW] && !dv_vel_q[QW].coinc |->
      (dv_qx_q[QW] <= OneW) && (dv_qy_q[QW] <= OneW))
    else $error("normal component above one");

endmodule

[tb/circle_collision_velocity_response_test.sv]
`timescale 1ns / 1ps

module circle_collision_velocity_response_test;

  localparam int unsigned FracBits = ccvr_pkg::FracBitsDef;
  localparam int unsigned Latency = FracBits + 28;
  localparam int unsigned MaxCycles = 400000;

  // One contact request as presented to the block.
  typedef struct {
    logic signed [31:0] pax, pay, pbx, pby;
    logic signed [31:0] vax, vay, vbx, vby;
    logic [31:0]        ma, mb;
    logic [16:0]        ba, bb;
  } contact_t;

  // One resolved velocity set.
  typedef struct {
    logic signed [31:0] vax, vay, vbx, vby;
    logic               hit;
  } response_t;

  // Keeps the responses still owed by the block and checks each one as it arrives.
  class response_board;
    response_t owed[$];
    int unsigned faults;

    function new();
      faults = 0;
    endfunction

    function logic [31:0] clip(longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
    endfunction

    // Works out the response of one contact in the block's fixed point.
    function response_t resolve(contact_t c);
      longint dx, dy, nx, ny, rel, r, ja, jb, swa, swb;
      longint unsigned ax, ay, m, sq, len, tot, wa, wb, ua, ub;
      response_t q;
      q.vax = c.vax; q.vay = c.vay; q.vbx = c.vbx; q.vby = c.vby; q.hit = 1'b0;
      dx = longint'(c.pax) - longint'(c.pbx);
      dy = longint'(c.pay) - longint'(c.pby);
      if (dx == 0 && dy == 0) return q;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      m = (ax > ay) ? ax : ay;
      // Bring the larger offset into the range 2^14 up to 2^15.
      while (m >= 64'd32768) begin
        ax = ax >> 1; ay = ay >> 1; m = m >> 1;
      end
      while (m < 64'd16384) begin
        ax = ax << 1; ay = ay << 1; m = m << 1;
      end
      sq = ax * ax + ay * ay;
      len = 0;
      for (int i = 15; i >= 0; i--) begin
        if ((len | (64'd1 << i)) * (len | (64'd1 << i)) <= sq) len = len | (64'd1 << i);
      end
      nx = longint'((ax << FracBits) / len);
      ny = longint'((ay << FracBits) / len);
      if (dx < 0) nx = -nx;
      if (dy < 0) ny = -ny;
      rel = ((longint'(c.vax) - longint'(c.vbx)) * nx
           + (longint'(c.vay) - longint'(c.vby)) * ny) >>> FracBits;
      if (rel > 0) return q;
      ua = c.ma; ub = c.mb;
      tot = ua + ub;
      if (tot == 0) begin
        wa = 64'd1 << (FracBits - 1);
        wb = wa;
      end else begin
        wa = (ua << FracBits) / tot;
        wb = (ub << FracBits) / tot;
      end
      swa = longint'(wa); swb = longint'(wb);
      ua = c.ba; ub = c.bb;
      r = longint'((ua * ub) >> 16);
      ja = (((2 * rel * swb) >>> FracBits) * r) >>> 16;
      jb = (((2 * rel * swa) >>> FracBits) * r) >>> 16;
      q.vax = clip(longint'(c.vax) - ((ja * nx) >>> FracBits));
      q.vay = clip(longint'(c.vay) - ((ja * ny) >>> FracBits));
      q.vbx = clip(longint'(c.vbx) + ((jb * nx) >>> FracBits));
      q.vby = clip(longint'(c.vby) + ((jb * ny) >>> FracBits));
      q.hit = 1'b1;
      return q;
    endfunction

    function void note_request(contact_t c);
      owed.push_back(resolve(c));
    endfunction

    function void check_response(response_t got);
      response_t want;
      if (owed.size() == 0) begin
        $error("response with no request outstanding");
        faults++;
        return;
      end
      want = owed.pop_front();
      if (got.vax !== want.vax) begin
        $error("new_vel_a_x: expected %0d, got %0d", want.vax, got.vax); faults++;
      end
      if (got.vay !== want.vay) begin
        $error("new_vel_a_y: expected %0d, got %0d", want.vay, got.vay); faults++;
      end
      if (got.vbx !== want.vbx) begin
        $error("new_vel_b_x: expected %0d, got %0d", want.vbx, got.vbx); faults++;
      end
      if (got.vby !== want.vby) begin
        $error("new_vel_b_y: expected %0d, got %0d", want.vby, got.vby); faults++;
      end
      if (got.hit !== want.hit) begin
        $error("impulse_applied: expected %0b, got %0b", want.hit, got.hit); faults++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] pos_a_x_i = '0, pos_a_y_i = '0, pos_b_x_i = '0, pos_b_y_i = '0;
  logic signed [31:0] vel_a_x_i = '0, vel_a_y_i = '0, vel_b_x_i = '0, vel_b_y_i = '0;
  logic [31:0] mass_a_i = 32'd1, mass_b_i = 32'd1;
  logic [16:0] bounce_a_i = '0, bounce_b_i = '0;
  logic signed [31:0] new_vel_a_x_o, new_vel_a_y_o, new_vel_b_x_o, new_vel_b_y_o;
  logic impulse_applied_o, done_o;

  response_board board = new();
  int unsigned cycles = 0;

  circle_collision_velocity_response DUT (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Record accepted requests and check responses at every edge.
  always @(posedge clk_i) begin
    contact_t c;
    response_t r;
    cycles <= cycles + 1;
    if (rst_ni && start && !busy) begin
      c.pax = pos_a_x_i; c.pay = pos_a_y_i; c.pbx = pos_b_x_i; c.pby = pos_b_y_i;
      c.vax = vel_a_x_i; c.vay = vel_a_y_i; c.vbx = vel_b_x_i; c.vby = vel_b_y_i;
      c.ma = mass_a_i; c.mb = mass_b_i; c.ba = bounce_a_i; c.bb = bounce_b_i;
      board.note_request(c);
    end
    if (rst_ni && done_o) begin
      r.vax = new_vel_a_x_o; r.vay = new_vel_a_y_o;
      r.vbx = new_vel_b_x_o; r.vby = new_vel_b_y_o; r.hit = impulse_applied_o;
      board.check_response(r);
    end
    if (cycles > MaxCycles) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Present one request and hold it until the block takes it.
  task automatic offer(contact_t c);
    pos_a_x_i <= c.pax; pos_a_y_i <= c.pay; pos_b_x_i <= c.pbx; pos_b_y_i <= c.pby;
    vel_a_x_i <= c.vax; vel_a_y_i <= c.vay; vel_b_x_i <= c.vbx; vel_b_y_i <= c.vby;
    mass_a_i <= c.ma; mass_b_i <= c.mb; bounce_a_i <= c.ba; bounce_b_i <= c.bb;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // A value that is fully random, small, moderate or near the signed extremes, so that all these regimes occur.
  function automatic logic [31:0] any_word();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 2000) - 1000;
      2: return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF - $urandom_range(0, 5)
                                             : 32'h8000_0000 + $urandom_range(0, 5);
      default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    endcase
  endfunction

  function automatic contact_t random_contact();
    contact_t c;
    c.pax = any_word(); c.pay = any_word();
    if ($urandom_range(0, 9) == 0) begin
      c.pbx = c.pax; c.pby = c.pay;
    end else begin
      c.pbx = ($urandom_range(0, 1) != 0) ? any_word() : c.pax + ($urandom_range(0, 8191) - 4096);
      c.pby = ($urandom_range(0, 1) != 0) ? any_word() : c.pay + ($urandom_range(0, 8191) - 4096);
    end
    c.vax = any_word(); c.vay = any_word(); c.vbx = any_word(); c.vby = any_word();
    // Mostly head the bodies towards each other so that impulses are frequent.
    if ($urandom_range(0, 3) != 0) begin
      c.vax = (c.pax > c.pbx) ? -($urandom_range(0, 32'h7FFF_FFFF)) : $urandom_range(0, 32'h7FFF_FFFF);
      c.vbx = (c.pax > c.pbx) ? $urandom_range(0, 32'h7FFF_FFFF) : -($urandom_range(0, 32'h7FFF_FFFF));
      if ($urandom_range(0, 1) != 0) begin
        c.vax = c.vax >>> 12; c.vbx = c.vbx >>> 12;
      end
    end
    c.ma = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 32'hFFFF_FFFF) : $urandom_range(1, 1 << 20);
    c.mb = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 32'hFFFF_FFFF) : $urandom_range(1, 1 << 20);
    c.ba = ($urandom_range(0, 7) == 0) ? 17'd65536 : 17'($urandom_range(0, 65536));
    c.bb = ($urandom_range(0, 7) == 0) ? 17'd65536 : 17'($urandom_range(0, 65536));
    return c;
  endfunction

  function automatic contact_t plain(int ax, int bx, int va, int vb);
    contact_t c;
    c.pax = ax; c.pay = 0; c.pbx = bx; c.pby = 0;
    c.vax = va; c.vay = 0; c.vbx = vb; c.vby = 0;
    c.ma = 32'h0001_0000; c.mb = 32'h0001_0000; c.ba = 17'd65536; c.bb = 17'd65536;
    return c;
  endfunction

  initial begin
    contact_t c;
    int unsigned burst;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: head-on, separating, coincident, at rest, extremes.
    offer(plain(32'h0002_0000, 0, -32'h0001_0000, 32'h0001_0000));
    offer(plain(32'h0002_0000, 0, 32'h0001_0000, -32'h0001_0000));
    offer(plain(5, 5, 32'h0001_0000, 0));
    offer(plain(32'h0001_0000, 0, 0, 0));
    offer(plain(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
    offer(plain(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
    c = plain(1, 0, -32'h4000_0000, 32'h4000_0000);
    c.ma = 32'd1; c.mb = 32'hFFFF_FFFF;
    offer(c);
    c.ma = 32'hFFFF_FFFF; c.mb = 32'd1; c.ba = 17'd0;
    offer(c);
    c.ba = 17'd65536; c.bb = 17'd0;
    offer(c);
    c = plain(0, 32'h0003_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    c.pay = 32'h0003_0000; c.ma = 32'hFFFF_FFFF; c.mb = 32'hFFFF_FFFF;
    offer(c);
    c = plain(-7, 3, 32'd100, -32'd100);
    c.pay = 32'h8000_0000; c.pby = 32'h7FFF_FFFF; c.vay = 32'h7FFF_FFFF; c.vby = 32'h8000_0000;
    offer(c);
    start <= 1'b0;
    @(posedge clk_i);

    // Random bursts separated by random gaps, some long runs back to back.
    for (int n = 0; n < 800; ) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && n < 800; k++, n++) offer(random_contact());
      if (n < 800 && $urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    start <= 1'b0;

    while (board.owed.size() != 0) @(posedge clk_i);
    repeat (Latency + 8) @(posedge clk_i);
    if (board.faults == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
